@@ hw/rtl/sha1le_pkg.sv @@
// Shared types, constants and helper functions of the little-endian SHA-1 hasher.
`default_nettype none
package sha1le_pkg;

	localparam int unsigned WORDS   = 16;
	localparam int unsigned WADDR_W = $clog2(WORDS);
	localparam int unsigned ROUNDS  = 80;
	localparam int unsigned ROUND_W = $clog2(ROUNDS);
	localparam int unsigned COUNT_W = 61;

	localparam logic [31:0] K_R1 = 32'h5A827999;
	localparam logic [31:0] K_R2 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R3 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R4 = 32'hCA62C1D6;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_PREF,
		ST_ROUND,
		ST_FINAL
	} state_t;

	// Control from the sequencer to the round datapath.
	typedef struct packed {
		logic load;    // copy chaining words into the working variables
		logic step;    // run one round
		logic add;     // fold working variables into the chaining words
		logic reinit;  // restore the initial chaining words
	} rnd_ctrl_t;

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		return {x[30:0], x[31]};
	endfunction

	function automatic logic [31:0] rotl5(input logic [31:0] x);
		return {x[26:0], x[31:27]};
	endfunction

	function automatic logic [31:0] rotl30(input logic [31:0] x);
		return {x[1:0], x[31:2]};
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sha1le_req_if.sv @@
// Request channel: one byte append or one finish per beat.
`default_nettype none
interface sha1le_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] msg_byte;

	modport source (output valid, output req_type, output msg_byte, input ready);
	modport sink   (input valid, input req_type, input msg_byte, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/sha1le_dig_if.sv @@
// Digest channel: five chaining words per beat.
`default_nettype none
interface sha1le_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word0;
	logic [31:0] digest_word1;
	logic [31:0] digest_word2;
	logic [31:0] digest_word3;
	logic [31:0] digest_word4;

	modport source (output valid, output digest_word0, output digest_word1,
		output digest_word2, output digest_word3, output digest_word4, input ready);
	modport sink   (input valid, input digest_word0, input digest_word1,
		input digest_word2, input digest_word3, input digest_word4, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/sha1le_wmem.sv @@
// Sixteen-word block memory with one write port and one registered read port.
`default_nettype none
module sha1le_wmem (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [sha1le_pkg::WADDR_W-1:0] waddr,
	input  wire logic [31:0]                    wdata,
	input  wire logic [sha1le_pkg::WADDR_W-1:0] raddr,
	output      logic [31:0]                    rdata
);

	logic [31:0] mem [sha1le_pkg::WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ hw/rtl/sha1le_round.sv @@
// SHA-1 round datapath: schedule window, working variables and chaining words.
`default_nettype none
module sha1le_round (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire sha1le_pkg::rnd_ctrl_t          ctrl,
	input  wire logic [sha1le_pkg::ROUND_W-1:0] rnd,
	input  wire logic [31:0]                    mem_word,
	output      logic [31:0]                    sum [5]
);

	logic [31:0] win_q [16];
	logic [31:0] v_q [5];
	logic [31:0] h_q [5];
	logic [31:0] wt;
	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] tmp;

	always_comb begin
		if (rnd < 7'd16) begin
			wt = mem_word;
		end else begin
			wt = sha1le_pkg::rotl1(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0]);
		end
		if (rnd < 7'd20) begin
			f = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
			k = sha1le_pkg::K_R1;
		end else if (rnd < 7'd40) begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			k = sha1le_pkg::K_R2;
		end else if (rnd < 7'd60) begin
			f = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
			k = sha1le_pkg::K_R3;
		end else begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			k = sha1le_pkg::K_R4;
		end
		tmp = sha1le_pkg::rotl5(v_q[0]) + f + v_q[4] + k + wt;
		for (int i = 0; i < 5; i++) begin
			sum[i] = h_q[i] + v_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			for (int i = 0; i < 5; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (ctrl.step) begin
			v_q[0] <= tmp;
			v_q[1] <= v_q[0];
			v_q[2] <= sha1le_pkg::rotl30(v_q[1]);
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3];
		end
		if (ctrl.step) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= wt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= sha1le_pkg::H0_INIT;
			h_q[1] <= sha1le_pkg::H1_INIT;
			h_q[2] <= sha1le_pkg::H2_INIT;
			h_q[3] <= sha1le_pkg::H3_INIT;
			h_q[4] <= sha1le_pkg::H4_INIT;
		end else if (ctrl.reinit) begin
			h_q[0] <= sha1le_pkg::H0_INIT;
			h_q[1] <= sha1le_pkg::H1_INIT;
			h_q[2] <= sha1le_pkg::H2_INIT;
			h_q[3] <= sha1le_pkg::H3_INIT;
			h_q[4] <= sha1le_pkg::H4_INIT;
		end else if (ctrl.add) begin
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= sum[i];
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/sha1le_ctrl.sv @@
// Sequencer: byte packing, padding, length words and round counting.
`default_nettype none
module sha1le_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	sha1le_req_if.sink                          req,
	input  wire logic                           out_free,
	output      logic                           out_load,
	output      sha1le_pkg::rnd_ctrl_t          ctrl,
	output      logic [sha1le_pkg::ROUND_W-1:0] rnd,
	output      logic                           we,
	output      logic [sha1le_pkg::WADDR_W-1:0] waddr,
	output      logic [31:0]                    wdata,
	output      logic [sha1le_pkg::WADDR_W-1:0] raddr
);

	sha1le_pkg::state_t state_q, state_d;

	logic [sha1le_pkg::COUNT_W-1:0] count_q;
	logic [23:0]                    part_q;
	logic [63:0]                    len_q;
	logic [sha1le_pkg::WADDR_W-1:0] wp_q;
	logic [sha1le_pkg::ROUND_W-1:0] rnd_q;
	logic                           fin_q;
	logic                           lenblk_q;
	logic                           acc;
	logic [5:0]                     pos;
	logic [1:0]                     lane;
	logic [31:0]                    pad_word;

	assign pos  = count_q[5:0];
	assign lane = pos[1:0];
	assign acc  = req.valid && req.ready;
	assign rnd  = rnd_q;

	always_comb begin
		case (lane)
			2'd0:    pad_word = {24'd0, sha1le_pkg::PAD_BYTE};
			2'd1:    pad_word = {16'd0, sha1le_pkg::PAD_BYTE, part_q[7:0]};
			2'd2:    pad_word = {8'd0, sha1le_pkg::PAD_BYTE, part_q[15:0]};
			default: pad_word = {sha1le_pkg::PAD_BYTE, part_q};
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sha1le_pkg::ST_IDLE: begin
				if (acc && req.req_type == sha1le_pkg::REQ_APPEND && pos == 6'd63) begin
					state_d = sha1le_pkg::ST_PREF;
				end else if (acc && req.req_type == sha1le_pkg::REQ_FINISH) begin
					state_d = (pos[5:2] == 4'd15) ? sha1le_pkg::ST_PREF : sha1le_pkg::ST_PAD;
				end
			end
			sha1le_pkg::ST_PAD: begin
				if (wp_q == 4'd15) begin
					state_d = sha1le_pkg::ST_PREF;
				end
			end
			sha1le_pkg::ST_PREF: state_d = sha1le_pkg::ST_ROUND;
			sha1le_pkg::ST_ROUND: begin
				if (rnd_q == 7'(sha1le_pkg::ROUNDS - 1)) begin
					state_d = sha1le_pkg::ST_FINAL;
				end
			end
			sha1le_pkg::ST_FINAL: begin
				if (fin_q && !lenblk_q) begin
					state_d = sha1le_pkg::ST_PAD;
				end else if (!fin_q || out_free) begin
					state_d = sha1le_pkg::ST_IDLE;
				end
			end
			default: state_d = sha1le_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		req.ready = 1'b0;
		ctrl      = '0;
		out_load  = 1'b0;
		we        = 1'b0;
		waddr     = wp_q;
		wdata     = 32'd0;
		raddr     = '0;
		case (state_q)
			sha1le_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				waddr     = pos[5:2];
				if (req.req_type == sha1le_pkg::REQ_APPEND) begin
					wdata = {req.msg_byte, part_q};
					we    = acc && lane == 2'd3;
				end else begin
					wdata = pad_word;
					we    = acc;
				end
			end
			sha1le_pkg::ST_PAD: begin
				we = 1'b1;
				if (lenblk_q && wp_q == 4'd14) begin
					wdata = len_q[31:0];
				end else if (lenblk_q && wp_q == 4'd15) begin
					wdata = len_q[63:32];
				end
			end
			sha1le_pkg::ST_PREF: ctrl.load = 1'b1;
			sha1le_pkg::ST_ROUND: begin
				ctrl.step = 1'b1;
				raddr     = rnd_q[3:0] + 4'd1;
			end
			sha1le_pkg::ST_FINAL: begin
				if (fin_q && lenblk_q) begin
					out_load    = out_free;
					ctrl.reinit = out_free;
				end else begin
					ctrl.add = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sha1le_pkg::ST_IDLE;
			count_q  <= '0;
			wp_q     <= '0;
			rnd_q    <= '0;
			fin_q    <= 1'b0;
			lenblk_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				sha1le_pkg::ST_IDLE: begin
					if (acc && req.req_type == sha1le_pkg::REQ_APPEND) begin
						count_q <= count_q + 61'd1;
					end else if (acc) begin
						count_q  <= '0;
						fin_q    <= 1'b1;
						lenblk_q <= (pos < 6'd56);
						wp_q     <= pos[5:2] + 4'd1;
					end
				end
				sha1le_pkg::ST_PAD: wp_q <= wp_q + 4'd1;
				sha1le_pkg::ST_PREF: rnd_q <= '0;
				sha1le_pkg::ST_ROUND: rnd_q <= rnd_q + 7'd1;
				sha1le_pkg::ST_FINAL: begin
					if (fin_q && !lenblk_q) begin
						lenblk_q <= 1'b1;
						wp_q     <= '0;
					end else if (fin_q && out_free) begin
						fin_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && req.req_type == sha1le_pkg::REQ_APPEND) begin
			case (lane)
				2'd0:    part_q[7:0]   <= req.msg_byte;
				2'd1:    part_q[15:8]  <= req.msg_byte;
				2'd2:    part_q[23:16] <= req.msg_byte;
				default: ;
			endcase
		end
		if (acc && req.req_type == sha1le_pkg::REQ_FINISH) begin
			len_q <= {count_q, 3'b000};
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/sha1_little_endian_hasher.sv @@
// Top level of the streaming SHA-1 hasher with little-endian word packing.
`default_nettype none
// Each request beat either appends one message byte or finishes the message.
// Bytes are packed four to a little-endian word and written into a sixteen-word
// block memory; appends are taken back to back, and the byte that completes a
// 64-byte block starts a compression (one read prefetch, 80 rounds, one
// chaining add) during which no request is taken. A finish pads with 0x80 and
// zeros, writes the 64-bit bit count as two little-endian words, and compresses
// once for one length block (the zero-fill of the rest of the block writes it
// word by word), or twice when the padding spills into an extra block. The five
// chaining words then leave in one digest beat from an output register, and the
// state returns to the initial chaining value for the next message. Appends are
// accepted while an earlier digest still waits; a finish waits at its final
// step until that register is free. The rounds are the one loop that sets
// throughput: one round per cycle through the shared round unit.
module sha1_little_endian_hasher (
	input  wire logic    clk,
	input  wire logic    arst_n,
	sha1le_req_if.sink   req,
	sha1le_dig_if.source dig
);

	sha1le_pkg::rnd_ctrl_t          ctrl;
	logic [sha1le_pkg::ROUND_W-1:0] rnd;
	logic                           we;
	logic [sha1le_pkg::WADDR_W-1:0] waddr;
	logic [31:0]                    wdata;
	logic [sha1le_pkg::WADDR_W-1:0] raddr;
	logic [31:0]                    rdata;
	logic [31:0]                    sum [5];
	logic                           out_free;
	logic                           out_load;
	logic                           out_valid_q;
	logic [31:0]                    dig_q [5];

	// The digest register is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || dig.ready;

	sha1le_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.out_free (out_free),
		.out_load (out_load),
		.ctrl     (ctrl),
		.rnd      (rnd),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.raddr    (raddr)
	);

	sha1le_wmem u_wmem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	sha1le_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.rnd      (rnd),
		.mem_word (rdata),
		.sum      (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (dig.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The final sum is captured straight from the round unit's adders.
	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < 5; i++) begin
				dig_q[i] <= sum[i];
			end
		end
	end

	assign dig.valid        = out_valid_q;
	assign dig.digest_word0 = dig_q[0];
	assign dig.digest_word1 = dig_q[1];
	assign dig.digest_word2 = dig_q[2];
	assign dig.digest_word3 = dig_q[3];
	assign dig.digest_word4 = dig_q[4];

endmodule
`default_nettype wire
